// ===== design/cstrr_pkg.sv =====
// Shared types and constants for the container slot table.
package cstrr_pkg;

   localparam int NUM_CONTAINERS_DEF = 8;
   localparam int NUM_PROCESSES_DEF  = 64;

   localparam int MODE_W = 3;
   localparam int CID_W  = 3;
   localparam int PID_W  = 6;
   localparam int LAST_W = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC  = 3'd0,
      MODE_DESTROY = 3'd1,
      MODE_ADD    = 3'd2,
      MODE_REMOVE = 3'd3,
      MODE_PICK   = 3'd4,
      MODE_SETLAST = 3'd5,
      MODE_QUERY  = 3'd6
   } cstrr_mode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } cstrr_state_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CID_W-1:0]  container_id;
      logic [PID_W-1:0]  process_id;
      logic [LAST_W-1:0] last_process_value;
   } cstrr_req_type;

   typedef struct packed {
      logic              fail;
      logic [CID_W-1:0]  slot_out;
      logic              member;
      logic              alive_out;
      logic [LAST_W-1:0] last_process_out;
   } cstrr_rsp_type;

endpackage

// ===== design/cstrr_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transfer.
interface cstrr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cstrr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cstrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/container_slot_table_round_robin_top.sv =====
// A transfer registers the request and starts the RAM read; the result register loads
// in the execute state, and a result still waiting in the output register holds that
// execute. A new request is taken only in the idle state, so the block does not accept
// one until the previous execute has finished.
// Reset clears alive flags, RAM valid bits, run pointer and channel state;
// RAM contents are not swept and read as zero until written.
module container_slot_table_round_robin_top #(
   parameter int NUM_CONTAINERS = cstrr_pkg::NUM_CONTAINERS_DEF,
   parameter int NUM_PROCESSES  = cstrr_pkg::NUM_PROCESSES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   cstrr_stream_if.sink         req_stream,
   cstrr_stream_if.source       rsp_stream
);
   localparam int SLOT_W = $clog2(NUM_CONTAINERS);
   localparam int SEL_W  = (SLOT_W > cstrr_pkg::CID_W) ? SLOT_W : cstrr_pkg::CID_W;
   localparam int PROC_W = $clog2(NUM_PROCESSES);
   localparam int LAST_W = cstrr_pkg::LAST_W;

   cstrr_pkg::cstrr_state_type state_ff, state_in;
   cstrr_pkg::cstrr_req_type   req;
   cstrr_pkg::cstrr_rsp_type   rsp_data_ff, rsp_data_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NUM_CONTAINERS-1:0] alive_ff, alive_in;
   logic [NUM_CONTAINERS-1:0] mem_valid_ff, mem_valid_in;
   logic [NUM_CONTAINERS-1:0] lp_valid_ff, lp_valid_in;
   logic [SLOT_W-1:0]         ptr_ff, ptr_in;

   // request held for the execute state
   logic [cstrr_pkg::MODE_W-1:0] mode_ff;
   logic [cstrr_pkg::PID_W-1:0]  pid_ff;
   logic [LAST_W-1:0]            lastv_ff;
   logic [SEL_W-1:0]             tgt_ff, tgt_in;
   logic                         tgt_ok_ff, tgt_ok_in;
   logic                         found_ff, found_in;

   logic req_take, exec_on, exec_fire;

   logic              alloc_found;
   logic [SLOT_W-1:0] alloc_idx;
   logic              pick_found;
   logic [SLOT_W-1:0] pick_idx;

   logic [SLOT_W-1:0]        idx;
   logic [NUM_PROCESSES-1:0] mem_rd_raw, mem_rd, pid_mask;
   logic [LAST_W-1:0]        lp_rd_raw, lp_rd;
   logic                     mem_we, lp_we;
   logic [NUM_PROCESSES-1:0] mem_wdata;
   logic                     pid_ok;

   assign req = req_stream.data;

   // ---------------- control FSM ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cstrr_pkg::ST_IDLE: begin
            if (req_stream.valid) state_in = cstrr_pkg::ST_EXEC;
         end
         cstrr_pkg::ST_EXEC: begin
            if (exec_fire) state_in = cstrr_pkg::ST_IDLE;
         end
         default: state_in = cstrr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stream.ready = 1'b0;
      exec_on          = 1'b0;
      case (state_ff)
         cstrr_pkg::ST_IDLE: req_stream.ready = 1'b1;
         cstrr_pkg::ST_EXEC: exec_on = 1'b1;
         default: begin
            req_stream.ready = 1'b0;
            exec_on          = 1'b0;
         end
      endcase
   end

   assign req_take  = req_stream.valid && req_stream.ready;
   assign exec_fire = exec_on && (!rsp_valid_ff || rsp_stream.ready);

   // ---------------- slot searches on the alive flags ----------------
   always_comb begin
      alloc_found = 1'b0;
      alloc_idx   = '0;
      // scan downward so the lowest free slot from 1 wins
      for (int i = NUM_CONTAINERS - 1; i >= 1; i--) begin
         if (!alive_ff[i]) begin
            alloc_found = 1'b1;
            alloc_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      logic [SLOT_W:0] sum;
      pick_found = 1'b0;
      pick_idx   = ptr_ff;
      sum        = '0;
      // rotating search from pointer+1; downward so the nearest wins
      for (int i = NUM_CONTAINERS; i >= 1; i--) begin
         sum = (SLOT_W+1)'(ptr_ff) + (SLOT_W+1)'(i);
         if (sum >= (SLOT_W+1)'(NUM_CONTAINERS)) begin
            sum = sum - (SLOT_W+1)'(NUM_CONTAINERS);
         end
         if (alive_ff[sum[SLOT_W-1:0]]) begin
            pick_found = 1'b1;
            pick_idx   = sum[SLOT_W-1:0];
         end
      end
   end

   // target slot chosen at transfer so the RAM read has the right address
   always_comb begin
      tgt_in    = SEL_W'(req.container_id);
      tgt_ok_in = (32'(req.container_id) < NUM_CONTAINERS);
      found_in  = 1'b0;
      case (req.mode)
         cstrr_pkg::MODE_ALLOC: begin
            found_in  = alloc_found;
            tgt_in    = alloc_found ? SEL_W'(alloc_idx) : '0;
            tgt_ok_in = alloc_found;
         end
         cstrr_pkg::MODE_PICK: begin
            found_in  = pick_found;
            tgt_in    = SEL_W'(pick_idx);
            tgt_ok_in = 1'b1;
         end
         default: begin
            found_in = 1'b0;
         end
      endcase
   end

   // ---------------- state memories ----------------
   assign idx = tgt_ff[SLOT_W-1:0];

   cstrr_ram #(
      .WIDTH(NUM_PROCESSES),
      .DEPTH(NUM_CONTAINERS)
   ) u_member_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(idx),
      .wr_data(mem_wdata),
      .rd_en  (req_take),
      .rd_addr(tgt_in[SLOT_W-1:0]),
      .rd_data(mem_rd_raw)
   );

   cstrr_ram #(
      .WIDTH(LAST_W),
      .DEPTH(NUM_CONTAINERS)
   ) u_last_ram (
      .clock  (clock),
      .wr_en  (lp_we),
      .wr_addr(idx),
      .wr_data(lastv_ff),
      .rd_en  (req_take),
      .rd_addr(tgt_in[SLOT_W-1:0]),
      .rd_data(lp_rd_raw)
   );

   // zero until written: member since reset or destroy, last value since reset
   assign mem_rd = (tgt_ok_ff && mem_valid_ff[idx]) ? mem_rd_raw : '0;
   assign lp_rd  = (tgt_ok_ff && lp_valid_ff[idx]) ? lp_rd_raw : '0;

   assign pid_ok   = (32'(pid_ff) < NUM_PROCESSES);
   assign pid_mask = pid_ok ? (NUM_PROCESSES'(1) << pid_ff[PROC_W-1:0]) : '0;

   // ---------------- execute: modify, write back, build result ----------------
   always_comb begin
      logic alive_cur;
      alive_cur    = tgt_ok_ff && alive_ff[idx];
      alive_in     = alive_ff;
      mem_valid_in = mem_valid_ff;
      lp_valid_in  = lp_valid_ff;
      ptr_in       = ptr_ff;
      mem_we       = 1'b0;
      lp_we        = 1'b0;
      mem_wdata    = mem_rd | pid_mask;

      rsp_data_in.fail             = 1'b0;
      rsp_data_in.slot_out         = tgt_ff[cstrr_pkg::CID_W-1:0];
      rsp_data_in.member           = 1'b0;
      rsp_data_in.alive_out        = alive_cur;
      rsp_data_in.last_process_out = lp_rd;

      case (mode_ff)
         cstrr_pkg::MODE_ALLOC: begin
            rsp_data_in.fail      = !found_ff;
            rsp_data_in.alive_out = found_ff;
            if (found_ff) begin
               alive_in[idx] = 1'b1;
            end
         end
         cstrr_pkg::MODE_DESTROY: begin
            rsp_data_in.alive_out = 1'b0;
            if (tgt_ok_ff) begin
               alive_in[idx]     = 1'b0;
               mem_valid_in[idx] = 1'b0;
            end
         end
         cstrr_pkg::MODE_ADD, cstrr_pkg::MODE_REMOVE: begin
            rsp_data_in.fail = !alive_cur;
            mem_wdata = (mode_ff == cstrr_pkg::MODE_ADD) ? (mem_rd | pid_mask)
                                                         : (mem_rd & ~pid_mask);
            if (alive_cur) begin
               mem_we            = 1'b1;
               mem_valid_in[idx] = 1'b1;
            end
         end
         cstrr_pkg::MODE_PICK: begin
            // target already holds the kept pointer when nothing is alive
            ptr_in = idx;
         end
         cstrr_pkg::MODE_SETLAST: begin
            if (tgt_ok_ff) begin
               lp_we                        = 1'b1;
               lp_valid_in[idx]             = 1'b1;
               rsp_data_in.last_process_out = lastv_ff;
            end
         end
         cstrr_pkg::MODE_QUERY: begin
            rsp_data_in.member = tgt_ok_ff && ((mem_rd & pid_mask) != '0);
         end
         default: begin
            rsp_data_in.member = 1'b0;
         end
      endcase

      if (!exec_fire) begin
         alive_in     = alive_ff;
         mem_valid_in = mem_valid_ff;
         lp_valid_in  = lp_valid_ff;
         ptr_in       = ptr_ff;
         mem_we       = 1'b0;
         lp_we        = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stream.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cstrr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         alive_ff     <= '0;
         mem_valid_ff <= '0;
         lp_valid_ff  <= '0;
         ptr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         alive_ff     <= alive_in;
         mem_valid_ff <= mem_valid_in;
         lp_valid_ff  <= lp_valid_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff   <= req.mode;
         pid_ff    <= req.process_id;
         lastv_ff  <= req.last_process_value;
         tgt_ff    <= tgt_in;
         tgt_ok_ff <= tgt_ok_in;
         found_ff  <= found_in;
      end
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_stream.valid = rsp_valid_ff;
   assign rsp_stream.data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_slot0_never_alive: assert property (@(posedge clock) disable iff (reset)
      !alive_ff[0])
      else $error("slot 0 became alive");

   a_take_enters_exec: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == cstrr_pkg::ST_EXEC))
      else $error("transfer did not start execute");

   a_ptr_moves_on_pick: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(ptr_ff)) |->
         ($past(exec_fire) && ($past(mode_ff) == cstrr_pkg::MODE_PICK)))
      else $error("run pointer moved outside pick next");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $rose(rsp_valid_ff)) |-> $past(exec_fire))
      else $error("result appeared without execute");

endmodule
